// ----- rtl/core/three_axis_rate_pid_defines.svh -----
// Assertion macros shared by the three-axis rate PID RTL.
`ifndef THREE_AXIS_RATE_PID_DEFINES_SVH
`define THREE_AXIS_RATE_PID_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during rst.
`define TPID_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during rst.
`define TPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tpid_pkg.sv -----
// Types, constants and register codes of the three-axis rate PID.
`default_nettype none

package tpid_pkg;

  localparam int AXES    = 3;
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;

  // field and register widths
  localparam int RATE_W   = 16;
  localparam int OUT_W    = 16;
  localparam int THR_W    = 13;
  localparam int GAINS_W  = 48;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int CFG_IDX_W = 3;

  // internal datapath widths
  localparam int FILT_FRAC = 16;
  localparam int ERR_W  = RATE_W + 1;
  localparam int FILT_W = RATE_W + FILT_FRAC;
  localparam int DIFF_W = FILT_W + 1;
  localparam int DY_W   = DIFF_W;
  localparam int SPLIT  = 16;
  localparam int HALF_W = DIFF_W - SPLIT;
  localparam int ITG_W  = 16;
  localparam int ITMP_W = ITG_W + 2;
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int P_W    = GAIN_W + ERR_W - 4;
  localparam int PD_W   = GAIN_W + DY_W + 1;
  localparam int NEG_W  = PD_W + 1;
  localparam int D_W    = NEG_W - 12;
  localparam int SUM_W  = D_W + 2;

  // 0.98 in Q16
  localparam logic signed [MUL_W-1:0] DECAY_Q16 = 18'sd64225;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAINS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAINS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAINS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITERM_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELAX_THR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_GAIN    = 3'd6;

  typedef logic signed [OUT_W-1:0] word_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] iterm_limit;
    logic [LIMIT_W-1:0] output_limit;
    logic [GAIN_W-1:0]  filt_gain;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic integrate;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_status_t;

  typedef enum logic [3:0] {
    LS_IDLE,
    LS_MUL_P,
    LS_MUL_I,
    LS_MUL_FH,
    LS_MUL_FL,
    LS_F_SUM,
    LS_MUL_DH,
    LS_MUL_DL,
    LS_D_SUM,
    LS_P_SUM,
    LS_CLAMP,
    LS_DONE
  } lane_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/tpid_mul.sv -----
// Registered 18x18 signed multiplier shared by the steps of one lane.
`default_nettype none

module tpid_mul (
  input  logic                                   clk,
  input  logic signed [tpid_pkg::MUL_W-1:0]      a,
  input  logic signed [tpid_pkg::MUL_W-1:0]      b,
  output logic signed [tpid_pkg::PROD_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tpid_lane.sv -----
// One axis of the rate PID: sequenced P, integrator, gyro filter and D steps.
`default_nettype none

module tpid_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tpid_pkg::lane_ctrl_t                  ctrl,
  input  tpid_pkg::cfg_t                        cfg,
  input  logic [tpid_pkg::GAINS_W-1:0]          gains,
  input  logic signed [tpid_pkg::RATE_W-1:0]    setpoint,
  input  logic signed [tpid_pkg::RATE_W-1:0]    gyro,
  output tpid_pkg::lane_status_t                status,
  output tpid_pkg::word_t                       drive,
  output tpid_pkg::word_t                       integral
);

  tpid_pkg::lane_state_t state, state_next;

  logic                                   integrate;
  logic signed [tpid_pkg::ERR_W-1:0]      err;
  logic signed [tpid_pkg::DIFF_W-1:0]     diff;
  logic signed [tpid_pkg::FILT_W-1:0]     filt;
  logic signed [tpid_pkg::ITG_W-1:0]      integ;
  logic signed [tpid_pkg::ITMP_W-1:0]     itmp;
  logic signed [tpid_pkg::PROD_W-1:0]     hi;
  logic signed [tpid_pkg::DY_W-1:0]       dy;
  logic signed [tpid_pkg::P_W-1:0]        pterm;
  logic signed [tpid_pkg::D_W-1:0]        dterm;
  logic signed [tpid_pkg::SUM_W-1:0]      sum;

  logic signed [tpid_pkg::MUL_W-1:0]      mul_a, mul_b;
  logic signed [tpid_pkg::PROD_W-1:0]     prod;

  logic [tpid_pkg::GAIN_W-1:0]            kp, kidt, kddt;
  logic signed [31:0]                     dec_round;
  logic signed [tpid_pkg::ITMP_W-1:0]     ilim, iclamp;
  logic signed [tpid_pkg::SUM_W-1:0]      olim, oclamp;
  logic signed [tpid_pkg::PD_W-1:0]       pd;
  logic signed [tpid_pkg::NEG_W-1:0]      neg;

  assign kp   = gains[15:0];
  assign kidt = gains[31:16];
  assign kddt = gains[47:32];

  tpid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpid_pkg::LS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      tpid_pkg::LS_IDLE: begin
        if (ctrl.start) state_next = tpid_pkg::LS_MUL_P;
      end
      tpid_pkg::LS_MUL_P: begin
        mul_a      = $signed({2'b00, kp});
        mul_b      = $signed({err[tpid_pkg::ERR_W-1], err});
        state_next = tpid_pkg::LS_MUL_I;
      end
      tpid_pkg::LS_MUL_I: begin
        if (integrate) begin
          mul_a = $signed({2'b00, kidt});
          mul_b = $signed({err[tpid_pkg::ERR_W-1], err});
        end else begin
          mul_a = tpid_pkg::DECAY_Q16;
          mul_b = $signed({{2{integ[tpid_pkg::ITG_W-1]}}, integ});
        end
        state_next = tpid_pkg::LS_MUL_FH;
      end
      tpid_pkg::LS_MUL_FH: begin
        mul_a      = $signed({2'b00, cfg.filt_gain});
        mul_b      = $signed({diff[tpid_pkg::DIFF_W-1],
                              diff[tpid_pkg::DIFF_W-1:tpid_pkg::SPLIT]});
        state_next = tpid_pkg::LS_MUL_FL;
      end
      tpid_pkg::LS_MUL_FL: begin
        mul_a      = $signed({2'b00, cfg.filt_gain});
        mul_b      = $signed({2'b00, diff[tpid_pkg::SPLIT-1:0]});
        state_next = tpid_pkg::LS_F_SUM;
      end
      tpid_pkg::LS_F_SUM: begin
        state_next = tpid_pkg::LS_MUL_DH;
      end
      tpid_pkg::LS_MUL_DH: begin
        mul_a      = $signed({2'b00, kddt});
        mul_b      = $signed({dy[tpid_pkg::DY_W-1],
                              dy[tpid_pkg::DY_W-1:tpid_pkg::SPLIT]});
        state_next = tpid_pkg::LS_MUL_DL;
      end
      tpid_pkg::LS_MUL_DL: begin
        mul_a      = $signed({2'b00, kddt});
        mul_b      = $signed({2'b00, dy[tpid_pkg::SPLIT-1:0]});
        state_next = tpid_pkg::LS_D_SUM;
      end
      tpid_pkg::LS_D_SUM:  state_next = tpid_pkg::LS_P_SUM;
      tpid_pkg::LS_P_SUM:  state_next = tpid_pkg::LS_CLAMP;
      tpid_pkg::LS_CLAMP:  state_next = tpid_pkg::LS_DONE;
      tpid_pkg::LS_DONE: begin
        if (ctrl.ack) state_next = tpid_pkg::LS_IDLE;
      end
      default: state_next = tpid_pkg::LS_IDLE;
    endcase
  end

  // decay truncates toward zero: bias negative products before the shift
  assign dec_round = prod[31:0] + (prod[tpid_pkg::PROD_W-1] ? 32'sd65535 : 32'sd0);

  assign ilim = $signed({3'b000, cfg.iterm_limit});
  always_comb begin
    if (itmp > ilim)       iclamp = ilim;
    else if (itmp < -ilim) iclamp = -ilim;
    else                   iclamp = itmp;
  end

  assign olim = $signed({{(tpid_pkg::SUM_W - tpid_pkg::LIMIT_W){1'b0}}, cfg.output_limit});
  always_comb begin
    if (sum > olim)       oclamp = olim;
    else if (sum < -olim) oclamp = -olim;
    else                  oclamp = sum;
  end

  // kd/dt * dy rebuilt from its two partial products
  assign pd  = $signed({hi[tpid_pkg::PD_W-tpid_pkg::SPLIT-1:0], 16'h0000})
             + $signed({18'h0, prod[31:0]});
  assign neg = -$signed({pd[tpid_pkg::PD_W-1], pd});

  // axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      filt  <= '0;
    end else begin
      case (state)
        tpid_pkg::LS_MUL_FL: begin
          integ <= integrate ? iclamp[tpid_pkg::ITG_W-1:0] : itmp[tpid_pkg::ITG_W-1:0];
        end
        tpid_pkg::LS_MUL_DH: begin
          filt <= filt + dy[tpid_pkg::FILT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      tpid_pkg::LS_IDLE: begin
        if (ctrl.start) begin
          integrate <= ctrl.integrate;
          err       <= $signed({setpoint[tpid_pkg::RATE_W-1], setpoint})
                     - $signed({gyro[tpid_pkg::RATE_W-1], gyro});
          diff      <= $signed({gyro[tpid_pkg::RATE_W-1], gyro, 16'h0000})
                     - $signed({filt[tpid_pkg::FILT_W-1], filt});
        end
      end
      tpid_pkg::LS_MUL_I: begin
        pterm <= prod[tpid_pkg::P_W+3:4];
      end
      tpid_pkg::LS_MUL_FH: begin
        if (integrate) begin
          itmp <= $signed({{2{integ[tpid_pkg::ITG_W-1]}}, integ})
                + $signed({prod[32], prod[32:16]});
        end else begin
          itmp <= $signed({{2{dec_round[31]}}, dec_round[31:16]});
        end
      end
      tpid_pkg::LS_MUL_FL: begin
        hi <= prod;
      end
      tpid_pkg::LS_F_SUM: begin
        dy <= hi[tpid_pkg::DY_W-1:0] + $signed({17'h0, prod[31:16]});
      end
      tpid_pkg::LS_MUL_DL: begin
        hi <= prod;
      end
      tpid_pkg::LS_D_SUM: begin
        dterm <= neg[tpid_pkg::NEG_W-1:12];
      end
      tpid_pkg::LS_P_SUM: begin
        sum <= $signed({{(tpid_pkg::SUM_W - tpid_pkg::P_W){pterm[tpid_pkg::P_W-1]}}, pterm})
             + $signed({{(tpid_pkg::SUM_W - tpid_pkg::ITG_W){integ[tpid_pkg::ITG_W-1]}}, integ})
             + $signed({{(tpid_pkg::SUM_W - tpid_pkg::D_W){dterm[tpid_pkg::D_W-1]}}, dterm});
      end
      tpid_pkg::LS_CLAMP: begin
        drive <= oclamp[tpid_pkg::OUT_W-1:0];
      end
      default: ;
    endcase
  end

  assign integral    = integ;
  assign status.busy = (state != tpid_pkg::LS_IDLE) && (state != tpid_pkg::LS_DONE);
  assign status.done = (state == tpid_pkg::LS_DONE);

endmodule

`default_nettype wire

// ----- rtl/core/tpid_merge.sv -----
// Gathers the three lane results into the registered output transfer stage.
`default_nettype none

module tpid_merge (
  input  logic                                           clk,
  input  logic                                           rst,
  input  tpid_pkg::lane_status_t [tpid_pkg::AXES-1:0]    status,
  input  tpid_pkg::word_t        [tpid_pkg::AXES-1:0]    drive_lane,
  input  tpid_pkg::word_t        [tpid_pkg::AXES-1:0]    integral_lane,
  output logic                                           ack,
  output logic                                           out_valid,
  input  logic                                           out_stall,
  output tpid_pkg::word_t                                drive_roll,
  output tpid_pkg::word_t                                drive_pitch,
  output tpid_pkg::word_t                                drive_yaw,
  output tpid_pkg::word_t                                integral_roll,
  output tpid_pkg::word_t                                integral_pitch,
  output tpid_pkg::word_t                                integral_yaw
);

  logic all_done;

  assign all_done = status[tpid_pkg::AX_ROLL].done && status[tpid_pkg::AX_PITCH].done &&
                    status[tpid_pkg::AX_YAW].done;
  assign ack      = all_done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      drive_roll     <= drive_lane[tpid_pkg::AX_ROLL];
      drive_pitch    <= drive_lane[tpid_pkg::AX_PITCH];
      drive_yaw      <= drive_lane[tpid_pkg::AX_YAW];
      integral_roll  <= integral_lane[tpid_pkg::AX_ROLL];
      integral_pitch <= integral_lane[tpid_pkg::AX_PITCH];
      integral_yaw   <= integral_lane[tpid_pkg::AX_YAW];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/three_axis_rate_pid.sv -----
// Top level of the three-axis rate PID: registers, input transfer and lanes.
//
// Input channel: in_valid/in_stall carries roll, pitch and yaw setpoints and
// gyro rates (Q4) plus throttle (Q12). A transfer happens on a rising edge
// with in_valid high and in_stall low. Output channel: out_valid/out_stall
// carries three clamped drive values and the three integrators (Q12), one
// result per input transfer.
// Each lane's sequencer runs six products through one shared 18x18
// multiplier and then the adds and clamps, one step a cycle; the merge stage
// then takes the result into its output register and the lane idles again.
// A lane takes no new item until it has handed its result to the merge stage.
// The three axes run side by side in identical lanes; the merge stage
// registers the result, so a new item is taken while a result waits.
// Reset (rst, synchronous): integrators and filter states clear, gains go
// to zero, both limits to 32767, relax throttle to 0, filter gain to 65535,
// out_valid drops and in_stall is held high. Configuration writes (cfg_wr_en)
// take effect at once and belong only to idle periods; an index outside the
// list is ignored.
// Receiver stall: the result holds on the outputs; the finished lanes wait
// and in_stall stays high until the output register frees.
`default_nettype none

`include "three_axis_rate_pid_defines.svh"

module three_axis_rate_pid (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [tpid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpid_pkg::GAINS_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tpid_pkg::RATE_W-1:0]    setpoint_roll,
  input  logic signed [tpid_pkg::RATE_W-1:0]    setpoint_pitch,
  input  logic signed [tpid_pkg::RATE_W-1:0]    setpoint_yaw,
  input  logic signed [tpid_pkg::RATE_W-1:0]    gyro_roll,
  input  logic signed [tpid_pkg::RATE_W-1:0]    gyro_pitch,
  input  logic signed [tpid_pkg::RATE_W-1:0]    gyro_yaw,
  input  logic [tpid_pkg::THR_W-1:0]            throttle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tpid_pkg::word_t                       drive_roll,
  output tpid_pkg::word_t                       drive_pitch,
  output tpid_pkg::word_t                       drive_yaw,
  output tpid_pkg::word_t                       integral_roll,
  output tpid_pkg::word_t                       integral_pitch,
  output tpid_pkg::word_t                       integral_yaw
);

  // configuration registers
  logic [tpid_pkg::GAINS_W-1:0] gains [tpid_pkg::AXES];
  logic [tpid_pkg::THR_W-1:0]   relax_throttle;
  tpid_pkg::cfg_t               cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains[tpid_pkg::AX_ROLL]  <= '0;
      gains[tpid_pkg::AX_PITCH] <= '0;
      gains[tpid_pkg::AX_YAW]   <= '0;
      cfg.iterm_limit           <= '1;
      cfg.output_limit          <= '1;
      cfg.filt_gain             <= '1;
      relax_throttle            <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpid_pkg::REG_ROLL_GAINS:   gains[tpid_pkg::AX_ROLL]  <= cfg_data;
        tpid_pkg::REG_PITCH_GAINS:  gains[tpid_pkg::AX_PITCH] <= cfg_data;
        tpid_pkg::REG_YAW_GAINS:    gains[tpid_pkg::AX_YAW]   <= cfg_data;
        tpid_pkg::REG_ITERM_LIMIT:  cfg.iterm_limit  <= cfg_data[tpid_pkg::LIMIT_W-1:0];
        tpid_pkg::REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data[tpid_pkg::LIMIT_W-1:0];
        tpid_pkg::REG_RELAX_THR:    relax_throttle   <= cfg_data[tpid_pkg::THR_W-1:0];
        tpid_pkg::REG_FILT_GAIN:    cfg.filt_gain    <= cfg_data[tpid_pkg::GAIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // lane fan-out
  logic signed [tpid_pkg::RATE_W-1:0]            sp_lane [tpid_pkg::AXES];
  logic signed [tpid_pkg::RATE_W-1:0]            gy_lane [tpid_pkg::AXES];
  tpid_pkg::lane_status_t [tpid_pkg::AXES-1:0]   lane_status;
  tpid_pkg::word_t        [tpid_pkg::AXES-1:0]   drive_lane;
  tpid_pkg::word_t        [tpid_pkg::AXES-1:0]   integral_lane;
  tpid_pkg::lane_ctrl_t                          lane_ctrl;
  logic                                          lane_ack;
  logic                                          in_accept;

  assign sp_lane[tpid_pkg::AX_ROLL]  = setpoint_roll;
  assign sp_lane[tpid_pkg::AX_PITCH] = setpoint_pitch;
  assign sp_lane[tpid_pkg::AX_YAW]   = setpoint_yaw;
  assign gy_lane[tpid_pkg::AX_ROLL]  = gyro_roll;
  assign gy_lane[tpid_pkg::AX_PITCH] = gyro_pitch;
  assign gy_lane[tpid_pkg::AX_YAW]   = gyro_yaw;

  // lanes run in lockstep; stall through reset and while any lane is
  // working or holding a result
  assign in_stall  = rst
                   || lane_status[tpid_pkg::AX_ROLL].busy
                   || lane_status[tpid_pkg::AX_ROLL].done
                   || lane_status[tpid_pkg::AX_PITCH].busy
                   || lane_status[tpid_pkg::AX_PITCH].done
                   || lane_status[tpid_pkg::AX_YAW].busy
                   || lane_status[tpid_pkg::AX_YAW].done;
  assign in_accept = in_valid && !in_stall;

  // integrator only integrates strictly above the relax throttle
  assign lane_ctrl.start     = in_accept;
  assign lane_ctrl.integrate = throttle > relax_throttle;
  assign lane_ctrl.ack       = lane_ack;

  for (genvar ax = 0; ax < tpid_pkg::AXES; ax++) begin : g_lane
    tpid_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl),
      .cfg      (cfg),
      .gains    (gains[ax]),
      .setpoint (sp_lane[ax]),
      .gyro     (gy_lane[ax]),
      .status   (lane_status[ax]),
      .drive    (drive_lane[ax]),
      .integral (integral_lane[ax])
    );
  end

  tpid_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .status         (lane_status),
    .drive_lane     (drive_lane),
    .integral_lane  (integral_lane),
    .ack            (lane_ack),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_roll     (drive_roll),
    .drive_pitch    (drive_pitch),
    .drive_yaw      (drive_yaw),
    .integral_roll  (integral_roll),
    .integral_pitch (integral_pitch),
    .integral_yaw   (integral_yaw)
  );

  // an accepted transfer starts all three lanes together
  `TPID_ASSERT_NEXT(a_start_all, in_accept, lane_status[0].busy && lane_status[1].busy && lane_status[2].busy, "lanes did not all start")
  // the lanes never drift apart
  `TPID_ASSERT_IMPL(a_lockstep, 1'b1, (lane_status[0] == lane_status[1]) && (lane_status[1] == lane_status[2]), "lanes out of step")
  // a working lane keeps the input stalled
  `TPID_ASSERT_IMPL(a_busy_stall, lane_status[0].busy, in_stall, "input open while lanes busy")
  // a merge load always presents a result next cycle
  `TPID_ASSERT_NEXT(a_ack_valid, lane_ack, out_valid, "merged result not presented")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the three-axis rate PID: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import tpid_pkg::*;

  // Result delay after the input transfer; pad generously around it.
  localparam int LATENCY     = 11;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 119;
  localparam int TIMEOUT_NS  = 2_000_000;
  localparam int MAX_REPORTS = 10;
  // Index past the register list: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // 0.98 in Q16, used on the integrator decay path.
  localparam longint DECAY_098 = 64225;
  localparam longint ACC_BOUND = 64'sd2147483647;

  typedef struct packed {
    word_t [AXES-1:0]   sp;
    word_t [AXES-1:0]   gy;
    logic  [THR_W-1:0]  thr;
  } rate_sample_t;

  typedef struct packed {
    word_t [AXES-1:0] drive;
    word_t [AXES-1:0] integ;
  } drive_set_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // One line of the directed table: a register write or an input transfer.
  // Where typed is set, want holds the hand-worked result.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [GAINS_W-1:0]     data;
    rate_sample_t           s;
    logic                   typed;
    drive_set_t             want;
  } script_row_t;

  // ---------------------------------------------------------------------------
  // DUT inputs are known from time zero; afterwards they change only by
  // nonblocking assignment at the rising edge.
  logic                  clk;
  logic                  rst            = 1'b1;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [GAINS_W-1:0]    cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  word_t                 setpoint_roll  = '0;
  word_t                 setpoint_pitch = '0;
  word_t                 setpoint_yaw   = '0;
  word_t                 gyro_roll      = '0;
  word_t                 gyro_pitch     = '0;
  word_t                 gyro_yaw       = '0;
  logic [THR_W-1:0]      throttle       = '0;
  logic                  out_stall      = 1'b0;

  logic                  in_stall;
  logic                  out_valid;
  word_t                 drive_roll, drive_pitch, drive_yaw;
  word_t                 integral_roll, integral_pitch, integral_yaw;

  three_axis_rate_pid i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .setpoint_roll  (setpoint_roll),
    .setpoint_pitch (setpoint_pitch),
    .setpoint_yaw   (setpoint_yaw),
    .gyro_roll      (gyro_roll),
    .gyro_pitch     (gyro_pitch),
    .gyro_yaw       (gyro_yaw),
    .throttle       (throttle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_roll     (drive_roll),
    .drive_pitch    (drive_pitch),
    .drive_yaw      (drive_yaw),
    .integral_roll  (integral_roll),
    .integral_pitch (integral_pitch),
    .integral_yaw   (integral_yaw)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Controller model: own copy of registers and per-axis state, reset values.
  logic [GAINS_W-1:0] gains_cfg [AXES] = '{default: '0};
  logic [LIMIT_W-1:0] iterm_cap = 15'h7FFF;
  logic [LIMIT_W-1:0] drive_cap = 15'h7FFF;
  logic [THR_W-1:0]   relax_thr = '0;
  logic [GAIN_W-1:0]  filt_gain = 16'hFFFF;
  longint             integ_acc [AXES] = '{default: 0};
  longint             rate_filt [AXES] = '{default: 0};

  drive_set_t   drive_due [$];   // results owed by the block, oldest first
  script_row_t  script [$];
  int           mismatches = 0;
  bit           steady = 1'b0;   // set: neither side idles

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] data);
    case (idx)
      REG_ROLL_GAINS:   gains_cfg[AX_ROLL]  = data;
      REG_PITCH_GAINS:  gains_cfg[AX_PITCH] = data;
      REG_YAW_GAINS:    gains_cfg[AX_YAW]   = data;
      REG_ITERM_LIMIT:  iterm_cap = data[LIMIT_W-1:0];
      REG_OUTPUT_LIMIT: drive_cap = data[LIMIT_W-1:0];
      REG_RELAX_THR:    relax_thr = data[THR_W-1:0];
      REG_FILT_GAIN:    filt_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // One control step for all three axes; updates the model state.
  function automatic drive_set_t advance_pid(rate_sample_t s);
    drive_set_t r;
    longint     spv, gyv, err, kp, kidt, kddt, fg, p, d, v, y_old, y_new, sum;
    logic       integrate;
    int         a;
    integrate = s.thr > relax_thr;
    fg = filt_gain;
    for (a = 0; a < AXES; a++) begin
      spv  = $signed(s.sp[a]);
      gyv  = $signed(s.gy[a]);
      err  = spv - gyv;
      kp   = gains_cfg[a][15:0];
      kidt = gains_cfg[a][31:16];
      kddt = gains_cfg[a][47:32];
      p = (kp * err) >>> 4;
      if (integrate) begin
        v = integ_acc[a] + ((kidt * err) >>> 16);
        v = clamp_mag(v, ACC_BOUND);
        integ_acc[a] = clamp_mag(v, longint'(iterm_cap));
      end else begin
        // decay truncates toward zero so small values die out; no clamp here
        v = integ_acc[a] * DECAY_098;
        integ_acc[a] = (v < 0) ? -((-v) >>> 16) : (v >>> 16);
      end
      y_old = rate_filt[a];
      y_new = y_old + ((fg * (gyv * 65536 - y_old)) >>> 16);
      rate_filt[a] = y_new;
      d = (-kddt * (y_new - y_old)) >>> 12;
      sum = clamp_mag(p + integ_acc[a] + d, longint'(drive_cap));
      r.drive[a] = sum[15:0];
      r.integ[a] = integ_acc[a][15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Small builders for stimulus.
  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic word_t sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return word_t'(v);
  endfunction

  // Random bits above the register width; the block must mask them off.
  function automatic logic [GAINS_W-1:0] with_junk(int w, logic [GAINS_W-1:0] v);
    logic [GAINS_W-1:0] mask, junk;
    mask = (48'd1 << w) - 48'd1;
    junk = GAINS_W'({$urandom, $urandom});
    return (junk & ~mask) | (v & mask);
  endfunction

  function automatic rate_sample_t mk_sample(int spr, int spp, int spy,
                                             int gyr, int gyp, int gyy, int thr);
    rate_sample_t s;
    s.sp[AX_ROLL]  = word_t'(spr);
    s.sp[AX_PITCH] = word_t'(spp);
    s.sp[AX_YAW]   = word_t'(spy);
    s.gy[AX_ROLL]  = word_t'(gyr);
    s.gy[AX_PITCH] = word_t'(gyp);
    s.gy[AX_YAW]   = word_t'(gyy);
    s.thr          = thr[THR_W-1:0];
    return s;
  endfunction

  function automatic drive_set_t mk_set(int dr, int dp, int dy, int ir, int ip, int iy);
    drive_set_t w;
    w.drive[AX_ROLL]  = word_t'(dr);
    w.drive[AX_PITCH] = word_t'(dp);
    w.drive[AX_YAW]   = word_t'(dy);
    w.integ[AX_ROLL]  = word_t'(ir);
    w.integ[AX_PITCH] = word_t'(ip);
    w.integ[AX_YAW]   = word_t'(iy);
    return w;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] data);
    script_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    script.push_back(row);
  endfunction

  function automatic void add_item(rate_sample_t s, logic typed, drive_set_t w);
    script_row_t row;
    row = '0;
    row.kind  = ROW_ITEM;
    row.s     = s;
    row.typed = typed;
    row.want  = w;
    script.push_back(row);
  endfunction

  // Directed table. Hand-worked rows are those that follow at a glance:
  // zero gains after reset, pure P with kp = 1.0, clamps, zero output limit.
  function automatic void build_script();
    // reset state: all gains zero, so everything reads zero
    add_item(mk_sample(32767, 32767, 32767, -32768, -32768, -32768, 4096), 1'b1,
             mk_set(0, 0, 0, 0, 0, 0));
    // throttle above full is compared as it stands
    add_item(mk_sample(-32768, -32768, -32768, 32767, 32767, 32767, 8191), 1'b1,
             mk_set(0, 0, 0, 0, 0, 0));
    // roll kp = 1.0 (Q4.12), nothing else: drive = 256 * error
    add_cfg(REG_ROLL_GAINS, 48'h0000_0000_1000);
    add_item(mk_sample(16, 0, 0, 0, 0, 0, 4096), 1'b1, mk_set(4096, 0, 0, 0, 0, 0));
    add_item(mk_sample(32767, 5, -5, -32768, 0, 0, 4096), 1'b1,
             mk_set(32767, 0, 0, 0, 0, 0));
    // negative clamp sits at -limit, not at the most negative code
    add_item(mk_sample(-32768, 0, 0, 32767, 0, 0, 0), 1'b1,
             mk_set(-32767, 0, 0, 0, 0, 0));
    // zero output limit forces the drive to zero
    add_cfg(REG_OUTPUT_LIMIT, 48'h0);
    add_item(mk_sample(32767, 0, 0, -32768, 0, 0, 4096), 1'b1, mk_set(0, 0, 0, 0, 0, 0));
    // integrator ramp and saturation; junk above bit 14 must be dropped
    add_cfg(REG_OUTPUT_LIMIT, 48'hABCD_0000_7FFF);
    add_cfg(REG_ROLL_GAINS,   48'h0010_FFFF_1000);
    add_cfg(REG_PITCH_GAINS,  48'h0010_FFFF_1000);
    add_cfg(REG_YAW_GAINS,    48'h0010_FFFF_1000);
    add_cfg(REG_ITERM_LIMIT,  48'h0000_0000_03E8);
    add_cfg(REG_FILT_GAIN,    48'h0);
    add_item(mk_sample(100, -100, 300, 0, 0, 0, 4096), 1'b0, '0);
    add_item(mk_sample(100, -100, 300, 0, 0, 0, 4096), 1'b0, '0);
    add_item(mk_sample(32767, -32768, 0, -32768, 32767, 0, 4096), 1'b0, '0);
    add_item(mk_sample(-1, 1, 0, 0, 0, 0, 1), 1'b0, '0);
    // relax threshold at full: at or below decays, above integrates
    add_cfg(REG_RELAX_THR, 48'h0000_0000_1000);
    add_item(mk_sample(50, 50, 50, 0, 0, 0, 4096), 1'b0, '0);
    add_item(mk_sample(50, 50, 50, 0, 0, 0, 4097), 1'b0, '0);
    add_item(mk_sample(50, 50, 50, 0, 0, 0, 0), 1'b0, '0);
    // limit lowered under a live integrator: only pulled in when integrating
    add_cfg(REG_ITERM_LIMIT, 48'h0);
    add_item(mk_sample(200, 200, 200, 0, 0, 0, 0), 1'b0, '0);
    add_item(mk_sample(200, 200, 200, 0, 0, 0, 8191), 1'b0, '0);
    // derivative with full-scale kd and an unfiltered gyro
    add_cfg(REG_ITERM_LIMIT, 48'h7FFF);
    add_cfg(REG_FILT_GAIN,   48'hFFFF);
    add_cfg(REG_ROLL_GAINS,  48'hFFFF_0100_0800);
    add_cfg(REG_PITCH_GAINS, 48'hFFFF_0100_0800);
    add_cfg(REG_YAW_GAINS,   48'hFFFF_0100_0800);
    add_item(mk_sample(0, 0, 0, 32767, -32768, 1, 4096), 1'b0, '0);
    add_item(mk_sample(0, 0, 0, -32768, 32767, -1, 4096), 1'b0, '0);
    add_item(mk_sample(0, 0, 0, 0, 0, 0, 4096), 1'b0, '0);
    // half-gain filter
    add_cfg(REG_FILT_GAIN, 48'h8000);
    add_item(mk_sample(10, 20, 30, 4000, -4000, 100, 4096), 1'b0, '0);
    // write to an unknown index: ignored
    add_cfg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
    add_item(mk_sample(10, 20, 30, 4000, -4000, 100, 4096), 1'b0, '0);
    // zero filter gain: filtered rate frozen, so no derivative
    add_cfg(REG_FILT_GAIN, 48'h0);
    add_item(mk_sample(-7, 7, 0, -20000, 20000, 3, 4096), 1'b0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Called at an edge; returns at the edge the transfer happened,
  // with in_valid still high so back-to-back transfers need no re-raise.
  task automatic send_sample(rate_sample_t s, logic typed, drive_set_t w);
    int         gap;
    drive_set_t pred;
    gap = 0;
    if (!steady && $urandom_range(99) < 34) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    setpoint_roll  <= s.sp[AX_ROLL];
    setpoint_pitch <= s.sp[AX_PITCH];
    setpoint_yaw   <= s.sp[AX_YAW];
    gyro_roll      <= s.gy[AX_ROLL];
    gyro_pitch     <= s.gy[AX_PITCH];
    gyro_yaw       <= s.gy[AX_YAW];
    throttle       <= s.thr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer at this edge: model steps in acceptance order
    pred = advance_pid(s);
    drive_due.push_back(typed ? w : pred);
  endtask

  // Drop valid, wait for every owed result, then let the lanes settle.
  task automatic drain_and_wait();
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Enable is pulsed for one cycle and dropped again before the task returns, so back-to-back
  // writes never assign the enable twice in one step.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    apply_cfg(idx, data);
  endtask

  // Register set for one random phase: first two are the extremes.
  task automatic load_phase_cfg(int ph);
    logic [GAINS_W-1:0] g [AXES];
    logic [LIMIT_W-1:0] il, ol;
    logic [THR_W-1:0]   rl;
    logic [GAIN_W-1:0]  fg;
    int                 a;
    case (ph)
      0: begin
        for (a = 0; a < AXES; a++) g[a] = '1;
        il = '1; ol = '1; rl = '0; fg = '1;
      end
      1: begin
        for (a = 0; a < AXES; a++) g[a] = '0;
        il = '0; ol = '0; rl = '1; fg = '0;
      end
      default: begin
        for (a = 0; a < AXES; a++) begin
          if (ph % 3 == 2) begin
            g[a] = GAINS_W'({$urandom, $urandom});
          end else begin
            g[a][15:0]  = GAIN_W'($urandom_range(0, 16383));
            g[a][31:16] = GAIN_W'($urandom_range(0, 65535));
            g[a][47:32] = GAIN_W'($urandom_range(0, 2047));
          end
        end
        il = LIMIT_W'($urandom_range(0, 32767));
        ol = LIMIT_W'($urandom_range(1024, 32767));
        rl = THR_W'($urandom_range(0, 4096));
        fg = GAIN_W'($urandom_range(0, 65535));
      end
    endcase
    cfg_write(REG_ROLL_GAINS,   g[AX_ROLL]);
    cfg_write(REG_PITCH_GAINS,  g[AX_PITCH]);
    cfg_write(REG_YAW_GAINS,    g[AX_YAW]);
    cfg_write(REG_ITERM_LIMIT,  with_junk(LIMIT_W, il));
    cfg_write(REG_OUTPUT_LIMIT, with_junk(LIMIT_W, ol));
    cfg_write(REG_RELAX_THR,    with_junk(THR_W, rl));
    cfg_write(REG_FILT_GAIN,    with_junk(GAIN_W, fg));
    cfg_write(REG_SPARE,        GAINS_W'({$urandom, $urandom}));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin : stimulus
    script_row_t  row;
    rate_sample_t s;
    int           i, ph, k, a, pick;
    int           bias [AXES];
    int           level [AXES];

    build_script();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        // registers only change with nothing in flight
        if (i == 0 || script[i-1].kind != ROW_CFG) drain_and_wait();
        cfg_write(row.idx, row.data);
      end else begin
        send_sample(row.s, row.typed, row.want);
      end
    end

    // Random phases: mostly a steady error bias with a slowly drifting gyro,
    // so integrators wind up, saturate and decay; some full-range noise and
    // occasional gyro steps to kick the derivative.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_and_wait();
      steady = (ph == 3);
      load_phase_cfg(ph);
      for (a = 0; a < AXES; a++) begin
        bias[a]  = jitter(3000);
        level[a] = 0;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold off once mid-phase until every result is back
        if (ph == 5 && k == PHASE_ITEMS / 2) drain_and_wait();
        pick = $urandom_range(99);
        for (a = 0; a < AXES; a++) begin
          if ($urandom_range(99) < 5) level[a] = jitter(4000);
          else level[a] = level[a] + jitter(24);
          if (pick < 15) begin
            s.sp[a] = word_t'($urandom);
            s.gy[a] = word_t'($urandom);
          end else begin
            s.sp[a] = sat16(bias[a] + jitter(48));
            s.gy[a] = sat16(level[a] + jitter(32));
          end
        end
        pick = $urandom_range(99);
        if (pick < 10) s.thr = THR_W'($urandom_range(0, 8191));
        else if (pick < 75) s.thr = THR_W'($urandom_range(relax_thr, 4096));
        else s.thr = THR_W'($urandom_range(0, relax_thr));
        send_sample(s, 1'b0, '0);
      end
    end

    steady = 1'b0;
    drain_and_wait();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && drive_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stall and result check. Values read here are the
  // ones present just before the edge, as the block saw them.
  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : receiver
    drive_set_t seen, want;
    int         a;
    if (!rst && out_valid && !out_stall) begin
      seen = mk_set(drive_roll, drive_pitch, drive_yaw,
                    integral_roll, integral_pitch, integral_yaw);
      if (drive_due.size() == 0) begin
        note_mismatch("unexpected transfer, drive_roll", 0, drive_roll);
      end else begin
        want = drive_due.pop_front();
        for (a = 0; a < AXES; a++) begin
          if (seen.drive[a] !== want.drive[a])
            note_mismatch($sformatf("drive axis %0d", a), want.drive[a], seen.drive[a]);
          if (seen.integ[a] !== want.integ[a])
            note_mismatch($sformatf("integral axis %0d", a), want.integ[a], seen.integ[a]);
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 34);
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tpid_pkg.sv
rtl/core/tpid_mul.sv
rtl/core/tpid_lane.sv
rtl/core/tpid_merge.sv
rtl/core/three_axis_rate_pid.sv
tb/sv/tb_top.sv
